>>> rtl/core/sil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg: shared types and constants of the sorted insert list
// Sizes of the list and of the stream payload, the entry record and the
// insert command that runs along the row of cells.
// ----------------------------------------------------------------------------
package sil_pkg;

    localparam int DEPTH      = 64;
    localparam int HANDLE_W   = 16;
    localparam int KEY_W      = 31;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // read tree: groups of eight cells, register stage after the first level only
    localparam int GRP_SIZE   = 8;
    localparam int GRP_W      = $clog2(GRP_SIZE);
    localparam int NUM_GRP    = DEPTH / GRP_SIZE;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    // input tdata layout
    localparam int IN_HANDLE_LSB = 0;
    localparam int IN_KEY_LSB    = IN_HANDLE_LSB + HANDLE_W;
    localparam int IN_POS_LSB    = IN_KEY_LSB + KEY_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_GROUP,
        ST_READ_SEL
    } state_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } entry_t;

    typedef struct packed {
        logic                wr;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } ins_cmd_t;

endpackage

>>> rtl/core/sil_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_cell: one compare-and-shift cell of the list
// Holds one entry. On an insert it takes its lower neighbour's entry when
// that one moves up, takes the new entry where it lands, or holds.
// ----------------------------------------------------------------------------
module sil_cell (
    input  logic              clk,
    input  sil_pkg::ins_cmd_t ins,
    input  logic              occupied,
    input  logic              at_tail,
    input  logic              prev_gt,
    input  sil_pkg::entry_t   prev_entry,
    output logic              gt,
    output sil_pkg::entry_t   entry
);

    sil_pkg::entry_t entry_reg;
    sil_pkg::entry_t entry_next;

    // strictly greater: equal keys stay below the new entry
    assign gt    = occupied && (entry_reg.key > ins.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ins.wr)
        begin
            if (prev_gt)
            begin
                entry_next = prev_entry;
            end
            else if (gt || at_tail)
            begin
                entry_next.handle = ins.handle;
                entry_next.key    = ins.key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/core/sil_read_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_read_tree: registered selection of one cell by position
// First level picks one cell in each group of eight and registers it; the
// second level picks the group.
// ----------------------------------------------------------------------------
module sil_read_tree (
    input  logic                                   clk,
    input  sil_pkg::entry_t [sil_pkg::DEPTH-1:0]   cells,
    input  logic [sil_pkg::IDX_W-1:0]              sel,
    output sil_pkg::entry_t                        entry
);

    sil_pkg::entry_t grp_reg  [sil_pkg::NUM_GRP];
    sil_pkg::entry_t grp_next [sil_pkg::NUM_GRP];

    always_comb
    begin
        for (int g = 0; g < sil_pkg::NUM_GRP; g++)
        begin
            grp_next[g] = cells[sil_pkg::IDX_W'(g * sil_pkg::GRP_SIZE)
                                + sil_pkg::IDX_W'(sel[sil_pkg::GRP_W-1:0])];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < sil_pkg::NUM_GRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    assign entry = grp_reg[sel[sil_pkg::IDX_W-1:sil_pkg::GRP_W]];

endmodule

>>> rtl/core/sorted_insert_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_list_core: bounded list of handles kept in key order
// Inserts land behind every entry with a key less than or equal to theirs;
// reads return the entry at a position. Every result reports the count.
//
//   channel  dir  tdata / tuser
//   s_*      in   tuser: action; tdata: node_handle, relevance, read_position
//   m_*      out  tdata: entry_count, list_full, read_valid, read_handle,
//                        read_relevance
//
// An insert completes at the accepting edge: every cell compares and shifts
// at once, and the result is written to the output register at that edge.
// A read passes the position register at the accepting edge, the group
// register of the read tree, then the output register.
// One request is in work at a time; the next is taken once the output
// register is empty or being emptied.
// Reset clears the count and the control state; cell contents are unset
// until written. A stalled output holds the result and the input.
// ----------------------------------------------------------------------------
module sorted_insert_list_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] node_handle, [46:16] relevance, [52:47] read_position, rest zero
    input  logic [sil_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] action
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] entry_count, [7] list_full, [8] read_valid, [24:9] read_handle,
    // [55:25] read_relevance
    output logic [sil_pkg::OUT_DATA_W-1:0]   m_tdata
);

    sil_pkg::state_t                       state_reg;
    sil_pkg::state_t                       state_next;
    logic [sil_pkg::CNT_W-1:0]             cnt_reg;
    logic [sil_pkg::CNT_W-1:0]             cnt_next;
    logic [sil_pkg::POS_W-1:0]             pos_reg;
    logic [sil_pkg::POS_W-1:0]             pos_next;
    logic                                  m_valid_reg;
    logic                                  m_valid_next;
    logic [sil_pkg::OUT_DATA_W-1:0]        m_data_reg;
    logic [sil_pkg::OUT_DATA_W-1:0]        m_data_next;

    logic                                  s_acc;
    logic                                  is_ins;
    logic                                  full;
    logic                                  out_free;
    logic                                  load_rd;
    logic                                  rd_valid;
    sil_pkg::ins_cmd_t                     ins;
    sil_pkg::entry_t [sil_pkg::DEPTH-1:0]  cells;
    logic [sil_pkg::DEPTH-1:0]             cell_gt;
    sil_pkg::entry_t                       rd_entry;

    assign s_acc    = s_tvalid && s_tready;
    assign is_ins   = (s_tuser == sil_pkg::ACT_INSERT);
    assign full     = (cnt_reg == sil_pkg::CNT_W'(sil_pkg::DEPTH));
    assign out_free = !m_valid_reg || m_tready;

    assign ins.wr     = s_acc && is_ins && !full;
    assign ins.handle = s_tdata[sil_pkg::IN_HANDLE_LSB +: sil_pkg::HANDLE_W];
    assign ins.key    = s_tdata[sil_pkg::IN_KEY_LSB +: sil_pkg::KEY_W];

    // row of cells, each fed by its lower neighbour
    for (genvar i = 0; i < sil_pkg::DEPTH; i++)
    begin : g_cell
        logic            prev_gt;
        sil_pkg::entry_t prev_entry;

        if (i == 0)
        begin : g_first
            assign prev_gt    = 1'b0;
            assign prev_entry = cells[0];
        end
        else
        begin : g_rest
            assign prev_gt    = cell_gt[i-1];
            assign prev_entry = cells[i-1];
        end

        sil_cell u_cell (
            .clk        (clk),
            .ins        (ins),
            .occupied   (sil_pkg::CNT_W'(i) < cnt_reg),
            .at_tail    (sil_pkg::CNT_W'(i) == cnt_reg),
            .prev_gt    (prev_gt),
            .prev_entry (prev_entry),
            .gt         (cell_gt[i]),
            .entry      (cells[i])
        );
    end

    sil_read_tree u_read_tree (
        .clk   (clk),
        .cells (cells),
        .sel   (sil_pkg::IDX_W'(pos_reg)),
        .entry (rd_entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sil_pkg::ST_IDLE:
            begin
                if (s_acc && !is_ins)
                begin
                    state_next = sil_pkg::ST_READ_GROUP;
                end
            end
            sil_pkg::ST_READ_GROUP:
            begin
                state_next = sil_pkg::ST_READ_SEL;
            end
            sil_pkg::ST_READ_SEL:
            begin
                if (out_free)
                begin
                    state_next = sil_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sil_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_rd  = 1'b0;
        case (state_reg)
            sil_pkg::ST_IDLE:
            begin
                s_tready = out_free;
            end
            sil_pkg::ST_READ_SEL:
            begin
                load_rd = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
                load_rd  = 1'b0;
            end
        endcase
    end

    assign rd_valid = (32'(pos_reg) < 32'(cnt_reg)) && (32'(pos_reg) < 32'(sil_pkg::DEPTH));

    always_comb
    begin
        cnt_next     = cnt_reg + sil_pkg::CNT_W'(ins.wr);
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_acc)
        begin
            pos_next = s_tdata[sil_pkg::IN_POS_LSB +: sil_pkg::POS_W];
        end
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (s_acc && is_ins)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {sil_pkg::KEY_W'(0), sil_pkg::HANDLE_W'(0), 1'b0, full,
                            sil_pkg::COUNT_W'(cnt_next)};
        end
        else if (load_rd)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {rd_valid ? rd_entry.key : sil_pkg::KEY_W'(0),
                            rd_valid ? rd_entry.handle : sil_pkg::HANDLE_W'(0),
                            rd_valid, 1'b0, sil_pkg::COUNT_W'(cnt_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sil_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sil_pkg::CNT_W'(sil_pkg::DEPTH))
        else $error("entry count above capacity");

    a_cnt_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        !ins.wr |=> $stable(cnt_reg))
        else $error("entry count moved without an insert");

    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sil_pkg::ST_IDLE) |-> !s_tready)
        else $error("request taken while a read is in work");

    a_full_flag_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && is_ins && full) |=> (m_tvalid && m_tdata[sil_pkg::COUNT_W]))
        else $error("refused insert not flagged");

    a_read_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sil_pkg::ST_READ_GROUP) |=> (state_reg == sil_pkg::ST_READ_SEL))
        else $error("read tree level skipped");
`endif

endmodule
